>>> hw/rtl/pix2x2_pkg.sv
// ----------------------------------------------------------------------------
// pix2x2_pkg
// Shared constants, types and helper function of the 2x2 pixelating block.
// ----------------------------------------------------------------------------
package pix2x2_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int LINE_SLOTS  = MAX_WIDTH / 2;
    localparam int SLOT_W      = $clog2(LINE_SLOTS);
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [8:0] COL_LIMIT = 9'(MAX_WIDTH / 2);
    localparam logic [8:0] ROW_LIMIT = 9'(MAX_HEIGHT / 2);

    // Configuration register indexes.
    localparam logic [1:0] REG_BLOCK_COLUMNS = 2'd0;
    localparam logic [1:0] REG_BLOCK_ROWS    = 2'd1;

    // One finished block on its way from the front to the back.
    typedef struct packed {
        logic [7:0] avg;
        logic [7:0] row_hi;   // block row, i.e. pixel row divided by two
        logic [7:0] col_hi;   // block column
        logic       last;     // last block of the frame
    } t_job;

    // Block count minus one, with zero read as one and large values saturated.
    function automatic logic [7:0] f_blocks_m1(input logic [8:0] v, input logic [8:0] limit);
        logic [8:0] c;
        begin
            c = v;
            if (c == 9'd0) begin
                c = 9'd1;
            end
            if (c > 9'd256) begin
                c = 9'd256;
            end
            if (c > limit) begin
                c = limit;
            end
            f_blocks_m1 = 8'(c - 9'd1);
        end
    endfunction

endpackage

>>> hw/rtl/pix2x2_ram.sv
// ----------------------------------------------------------------------------
// pix2x2_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pix2x2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pix2x2_front.sv
// ----------------------------------------------------------------------------
// pix2x2_front
// Pixel intake: raster position, pair sums in the line store and block average.
// ----------------------------------------------------------------------------
module pix2x2_front
    import pix2x2_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_pixel_value,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output logic       o_job_valid,
    output t_job       o_job
);

    logic [8:0] r_col;
    logic [8:0] r_row;
    logic [7:0] r_cols_m1;
    logic [7:0] r_rows_m1;
    logic [7:0] r_left;
    logic [8:0] n_col;
    logic [8:0] n_row;

    logic       col_last;
    logic       row_last;
    logic       line_we;
    logic       line_re;
    logic [8:0] pair_sum;
    logic [8:0] above;
    logic [9:0] total;

    assign col_last = (r_col == {r_cols_m1, 1'b1});
    assign row_last = (r_row == {r_rows_m1, 1'b1});

    assign pair_sum = {1'b0, r_left} + {1'b0, i_pixel_value};
    assign line_we  = i_accept & ~r_row[0] & r_col[0];
    // The stored pair is fetched on the left pixel, so it is ready for the right one.
    assign line_re  = i_accept & r_row[0] & ~r_col[0];

    pix2x2_ram #(
        .WIDTH (9),
        .DEPTH (LINE_SLOTS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_col[8:1]),
        .i_wdata (pair_sum),
        .i_re    (line_re),
        .i_raddr (r_col[8:1]),
        .o_rdata (above)
    );

    assign total = {1'b0, above} + {1'b0, pair_sum};

    assign o_job_valid   = i_accept & r_row[0] & r_col[0];
    assign o_job.avg     = total[9:2];
    assign o_job.row_hi  = r_row[8:1];
    assign o_job.col_hi  = r_col[8:1];
    assign o_job.last    = row_last & col_last;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (col_last) begin
                n_col = 9'd0;
                n_row = row_last ? 9'd0 : r_row + 9'd1;
            end else begin
                n_col = r_col + 9'd1;
            end
        end
        // A size write abandons the current frame.
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_COLUMNS, REG_BLOCK_ROWS: begin
                    n_col = 9'd0;
                    n_row = 9'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= 9'd0;
            r_row     <= 9'd0;
            r_left    <= 8'd0;
            r_cols_m1 <= 8'd255;
            r_rows_m1 <= 8'd255;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_accept && !r_col[0]) begin
                r_left <= i_pixel_value;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_COLUMNS: begin
                        r_cols_m1 <= f_blocks_m1(i_cfg_data, COL_LIMIT);
                    end
                    REG_BLOCK_ROWS: begin
                        r_rows_m1 <= f_blocks_m1(i_cfg_data, ROW_LIMIT);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/pix2x2_queue.sv
// ----------------------------------------------------------------------------
// pix2x2_queue
// Short first-in first-out queue of finished blocks between front and back.
// ----------------------------------------------------------------------------
module pix2x2_queue
    import pix2x2_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/pix2x2_back.sv
// ----------------------------------------------------------------------------
// pix2x2_back
// Result sequencer: turns each block into four pixel results, one per pop.
// ----------------------------------------------------------------------------
module pix2x2_back
    import pix2x2_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_block_average,
    output logic [8:0] o_pixel_row,
    output logic [8:0] o_pixel_column,
    output logic       o_run_end,
    output logic       o_frame_end
);

    logic       r_busy;
    logic [1:0] r_k;
    t_job       r_job;
    logic       take;
    logic       load;

    assign take    = i_pop & r_busy;
    // A new block is loaded when idle, or as the fourth result of the current one leaves.
    assign load    = ~i_q_empty & (~r_busy | (take & (r_k == 2'd3)));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (take) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_empty         = ~r_busy;
    assign o_block_average = r_job.avg;
    assign o_pixel_row     = {r_job.row_hi, r_k[1]};
    assign o_pixel_column  = {r_job.col_hi, r_k[0]};
    assign o_run_end       = (r_k == 2'd3);
    assign o_frame_end     = (r_k == 2'd3) & r_job.last;

endmodule

>>> hw/rtl/pixelate_two_by_two_average.sv
// ----------------------------------------------------------------------------
// pixelate_two_by_two_average
// Averages each 2x2 block of a grey raster image and writes the mean back to
// all four pixel positions of the block.
// ----------------------------------------------------------------------------
// Path: a block enters the block queue at the edge that accepts its last pixel;
// its first result is visible once the back has loaded it from the queue.
// Throughput: one pixel per cycle while the queue is not full; the back issues
// four results per block, so in odd rows the eight-entry block queue fills and
// holds back intake, which catches up in even rows, which produce no results.
// Reset: synchronous, active low; position cleared, both sizes set to 256 blocks.
// ----------------------------------------------------------------------------
module pixelate_two_by_two_average
    import pix2x2_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_pixel_value,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_block_average,
    output logic [8:0] o_pixel_row,
    output logic [8:0] o_pixel_column,
    output logic       o_run_end,
    output logic       o_frame_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job q_job;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push & ~q_full;

    pix2x2_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel_value (i_pixel_value),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_job_valid   (job_valid),
        .o_job         (front_job)
    );

    pix2x2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    pix2x2_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_job         (q_job),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_block_average (o_block_average),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_column  (o_pixel_column),
        .o_run_end       (o_run_end),
        .o_frame_end     (o_frame_end)
    );

endmodule
